FILE: hdl/ftwl_pkg.sv
// Shared types, constants and helpers of the flash translation wear leveller.
// No dependencies; imported by every module of the block.
package ftwl_pkg;

  localparam int NUM_BLOCKS_DEF      = 64;
  localparam int PAGES_PER_BLOCK_DEF = 32;
  localparam int NUM_LOGICAL_DEF     = 1024;

  localparam logic [15:0] WEAR_THR_RST = 16'd100;
  localparam logic [15:0] WEAR_LIM_RST = 16'd1000;
  localparam logic [15:0] WEAR_MAX     = 16'hFFFF;
  localparam logic [31:0] RDATA_NONE   = 32'hFFFF_FFFF;

  // command codes on the op field
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_LEVEL = 2'd2;

  // configuration register indexes
  localparam logic CFG_WEAR_THR = 1'b0;
  localparam logic CFG_WEAR_LIM = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_PAGE = 3'd1,
    ST_NO_MAP   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_NO_FREE  = 3'd4,
    ST_SKIPPED  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    K_WRITE,
    K_READ,
    K_LEVEL,
    K_BAD_PAGE,
    K_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] lp;
    logic [31:0] wd;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_MAP,
    S_RD_PAGE,
    S_SCAN,
    S_SCAN_END,
    S_WR_MAP,
    S_LV_RD,
    S_LV_CHK,
    S_LV_MOVE,
    S_LV_ERASE,
    S_LV_COLD,
    S_DONE
  } eng_state_e;

  function automatic int width_of(input int n);
    width_of = (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] w);
    sat_inc = (w == WEAR_MAX) ? w : w + 16'd1;
  endfunction

endpackage

FILE: hdl/ftwl_front.sv
// Front end: classifies each incoming command and range checks the page of writes and reads.
// Depends on ftwl_pkg.
module ftwl_front #(
  parameter int NUM_LOGICAL = ftwl_pkg::NUM_LOGICAL_DEF
) (
  input  logic [1:0]     op_i,
  input  logic [15:0]    page_num_i,
  input  logic [31:0]    write_data_i,
  output ftwl_pkg::cmd_t cmd_o
);
  import ftwl_pkg::*;

  logic bad_lp;

  assign bad_lp = {1'b0, page_num_i} >= 17'(NUM_LOGICAL);

  always_comb begin
    cmd_o.lp = page_num_i;
    cmd_o.wd = write_data_i;
    case (op_i)
      OP_WRITE: cmd_o.kind = bad_lp ? K_BAD_PAGE : K_WRITE;
      OP_READ:  cmd_o.kind = bad_lp ? K_BAD_PAGE : K_READ;
      OP_LEVEL: cmd_o.kind = K_LEVEL;
      default:  cmd_o.kind = K_NOP;
    endcase
  end

endmodule

FILE: hdl/ftwl_queue.sv
// Two-entry command queue between front end and engine.
// Depends on ftwl_pkg.
module ftwl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftwl_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ftwl_pkg::cmd_t data_o
);
  import ftwl_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: hdl/ftwl_engine.sv
// Back end: sequencer over map, block and page memories; holds the result register.
// Depends on ftwl_pkg.
module ftwl_engine #(
  parameter int NUM_BLOCKS      = ftwl_pkg::NUM_BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = ftwl_pkg::PAGES_PER_BLOCK_DEF,
  parameter int NUM_LOGICAL     = ftwl_pkg::NUM_LOGICAL_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ftwl_pkg::cmd_t        q_data_i,
  output logic                  q_pop_o,
  output logic                  clearing_o,
  input  logic [15:0]           wear_threshold_i,
  input  logic [15:0]           wear_limit_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           read_data_o,
  output ftwl_pkg::status_e     status_o,
  output logic [ftwl_pkg::width_of(NUM_BLOCKS)-1:0]        phys_block_o,
  output logic [ftwl_pkg::width_of(PAGES_PER_BLOCK)-1:0]   phys_page_o,
  output logic [$clog2(PAGES_PER_BLOCK+1)-1:0]             pages_moved_o
);
  import ftwl_pkg::*;

  localparam int BW    = width_of(NUM_BLOCKS);
  localparam int PW    = width_of(PAGES_PER_BLOCK);
  localparam int FW    = $clog2(PAGES_PER_BLOCK + 1);
  localparam int LW    = width_of(NUM_LOGICAL);
  localparam int MAP_W = 1 + BW + PW;
  localparam int BLK_W = 16 + FW;
  localparam int CLR_N = (NUM_LOGICAL > NUM_BLOCKS) ? NUM_LOGICAL : NUM_BLOCKS;
  localparam int CW    = width_of(CLR_N);
  localparam int PGD   = NUM_BLOCKS * (2 ** PW);

  // memories
  logic [MAP_W-1:0] map_mem [NUM_LOGICAL];
  logic [BLK_W-1:0] blk_mem [NUM_BLOCKS];
  logic             pst_mem [PGD];
  logic [31:0]      pdat_mem [PGD];
  logic [LW-1:0]    pown_mem [PGD];

  logic             map_we, blk_we, pst_we, pdo_we;
  logic [LW-1:0]    map_wa, map_ra;
  logic [MAP_W-1:0] map_wd, map_rd_q;
  logic [BW-1:0]    blk_wa, blk_ra;
  logic [BLK_W-1:0] blk_wd, blk_rd_q;
  logic [BW+PW-1:0] pst_wa, pdo_wa, pg_ra;
  logic             pst_wd, pst_rd_q;
  logic [31:0]      pdat_wd, pdat_rd_q;
  logic [LW-1:0]    pown_wd, pown_rd_q;

  eng_state_e state_q, state_d;
  cmd_t       cmd_q, cmd_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [BW:0]   idx_q, idx_d;
  logic [BW-1:0] hot_q, hot_d, cold_q, cold_d;
  logic [15:0]   hot_w_q, hot_w_d, cold_w_q, cold_w_d;
  logic [FW-1:0] hot_fill_q, hot_fill_d;
  logic          found_q, found_d;
  logic [FW-1:0] j_q, j_d, moved_q, moved_d;
  logic [31:0]   sv_data_q, sv_data_d;
  logic [LW-1:0] sv_owner_q, sv_owner_d;
  logic [MAP_W-1:0] rm_q, rm_d;
  logic [31:0]   res_rd_q, res_rd_d;
  status_e       res_st_q, res_st_d;
  logic [BW-1:0] res_pb_q, res_pb_d;
  logic [PW-1:0] res_pp_q, res_pp_d;
  logic [FW-1:0] res_mv_q, res_mv_d;
  logic          ov_q, ov_d;
  logic [31:0]   o_rd_q;
  status_e       o_st_q;
  logic [BW-1:0] o_pb_q;
  logic [PW-1:0] o_pp_q;
  logic [FW-1:0] o_mv_q;

  // decoded conditions
  logic          clr_last, scan_last, ev_valid, ev_hot, ev_cold, lv_skip;
  logic          rd_ok, mv_match, load_out;
  logic [BW-1:0] ev_idx;
  logic [15:0]   ev_w;
  logic [FW-1:0] ev_fill;
  logic [16:0]   gap;

  assign clr_last  = clr_q == CW'(CLR_N - 1);
  assign scan_last = idx_q == (BW+1)'(NUM_BLOCKS);
  assign ev_valid  = idx_q != '0;
  assign ev_idx    = BW'(idx_q - (BW+1)'(1));
  assign ev_w      = blk_rd_q[BLK_W-1 -: 16];
  assign ev_fill   = blk_rd_q[FW-1:0];
  assign ev_hot    = (ev_idx == '0) || (ev_w > hot_w_q);
  assign ev_cold   = (ev_fill == '0) && (ev_w <= wear_limit_i) &&
                     (!found_q || ev_w < cold_w_q);
  assign gap       = {1'b0, hot_w_q} - {1'b0, cold_w_q};
  assign lv_skip   = !found_q || (hot_q == cold_q) || (gap < {1'b0, wear_threshold_i});
  // page of a read must lie in the written prefix of its block and be valid
  assign rd_ok     = ({{(FW-PW){1'b0}}, rm_q[PW-1:0]} < blk_rd_q[FW-1:0]) && pst_rd_q;
  assign mv_match  = map_rd_q[MAP_W-1] && (map_rd_q[PW +: BW] == hot_q) &&
                     ({{(FW-PW){1'b0}}, map_rd_q[PW-1:0]} == j_q);
  assign load_out  = (state_q == S_DONE) && (!ov_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.kind)
            K_WRITE, K_LEVEL: state_d = S_SCAN;
            K_READ:           state_d = S_RD_MAP;
            default:          state_d = S_DONE;
          endcase
        end
      end
      S_RD_MAP:   state_d = map_rd_q[MAP_W-1] ? S_RD_PAGE : S_DONE;
      S_RD_PAGE:  state_d = S_DONE;
      S_SCAN:     if (scan_last) state_d = S_SCAN_END;
      S_SCAN_END: begin
        if (cmd_q.kind == K_WRITE) state_d = found_q ? S_WR_MAP : S_DONE;
        else                       state_d = lv_skip ? S_DONE : S_LV_RD;
      end
      S_WR_MAP:   state_d = S_DONE;
      S_LV_RD:    state_d = (j_q < hot_fill_q) ? S_LV_CHK : S_LV_ERASE;
      S_LV_CHK:   state_d = pst_rd_q ? S_LV_MOVE : S_LV_RD;
      S_LV_MOVE:  state_d = S_LV_RD;
      S_LV_ERASE: state_d = S_LV_COLD;
      S_LV_COLD:  state_d = S_DONE;
      S_DONE:     if (load_out) state_d = S_IDLE;
      default:    state_d = S_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d      = cmd_q;
    clr_d      = clr_q;
    idx_d      = idx_q;
    hot_d      = hot_q;
    hot_w_d    = hot_w_q;
    hot_fill_d = hot_fill_q;
    cold_d     = cold_q;
    cold_w_d   = cold_w_q;
    found_d    = found_q;
    j_d        = j_q;
    moved_d    = moved_q;
    sv_data_d  = sv_data_q;
    sv_owner_d = sv_owner_q;
    rm_d       = rm_q;
    res_rd_d   = res_rd_q;
    res_st_d   = res_st_q;
    res_pb_d   = res_pb_q;
    res_pp_d   = res_pp_q;
    res_mv_d   = res_mv_q;
    ov_d       = (ov_q && !out_ready_i) || load_out;
    q_pop_o    = 1'b0;
    map_we = 1'b0; map_wa = '0; map_wd = '0; map_ra = '0;
    blk_we = 1'b0; blk_wa = '0; blk_wd = '0; blk_ra = '0;
    pst_we = 1'b0; pst_wa = '0; pst_wd = 1'b0;
    pdo_we = 1'b0; pdo_wa = '0; pdat_wd = '0; pown_wd = '0;
    pg_ra  = '0;

    case (state_q)
      S_CLEAR: begin
        clr_d  = clr_q + CW'(1);
        map_we = {{(32-CW){1'b0}}, clr_q} < 32'(NUM_LOGICAL);
        map_wa = LW'(clr_q);
        blk_we = {{(32-CW){1'b0}}, clr_q} < 32'(NUM_BLOCKS);
        blk_wa = BW'(clr_q);
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          cmd_d    = q_data_i;
          map_ra   = q_data_i.lp[LW-1:0];
          idx_d    = '0;
          found_d  = 1'b0;
          res_rd_d = RDATA_NONE;
          res_st_d = (q_data_i.kind == K_BAD_PAGE) ? ST_BAD_PAGE : ST_OK;
          res_pb_d = '0;
          res_pp_d = '0;
          res_mv_d = '0;
        end
      end
      S_RD_MAP: begin
        rm_d   = map_rd_q;
        pg_ra  = map_rd_q[BW+PW-1:0];
        blk_ra = map_rd_q[PW +: BW];
        if (!map_rd_q[MAP_W-1]) res_st_d = ST_NO_MAP;
      end
      S_RD_PAGE: begin
        if (rd_ok) res_rd_d = pdat_rd_q;
        else       res_st_d = ST_INVALID;
      end
      S_SCAN: begin
        blk_ra = BW'(idx_q);
        idx_d  = idx_q + (BW+1)'(1);
        if (ev_valid) begin
          if (ev_hot) begin
            hot_d      = ev_idx;
            hot_w_d    = ev_w;
            hot_fill_d = ev_fill;
          end
          if (ev_cold) begin
            found_d  = 1'b1;
            cold_d   = ev_idx;
            cold_w_d = ev_w;
          end
        end
      end
      S_SCAN_END: begin
        j_d     = '0;
        moved_d = '0;
        if (cmd_q.kind == K_WRITE) begin
          if (!found_q) begin
            res_st_d = ST_NO_FREE;
          end else begin
            // a chosen block is empty, so the write lands on its first page
            pst_we  = 1'b1;
            pst_wa  = {cold_q, {PW{1'b0}}};
            pst_wd  = 1'b1;
            pdo_we  = 1'b1;
            pdo_wa  = {cold_q, {PW{1'b0}}};
            pdat_wd = cmd_q.wd;
            pown_wd = cmd_q.lp[LW-1:0];
            blk_we  = 1'b1;
            blk_wa  = cold_q;
            blk_wd  = {sat_inc(cold_w_q), FW'(1)};
            map_ra  = cmd_q.lp[LW-1:0];
            res_pb_d = cold_q;
          end
        end else if (lv_skip) begin
          res_st_d = ST_SKIPPED;
        end
      end
      S_WR_MAP: begin
        if (map_rd_q[MAP_W-1]) begin
          pst_we = 1'b1;
          pst_wa = map_rd_q[BW+PW-1:0];
          pst_wd = 1'b0;
        end
        map_we = 1'b1;
        map_wa = cmd_q.lp[LW-1:0];
        map_wd = {1'b1, cold_q, {PW{1'b0}}};
      end
      S_LV_RD: begin
        pg_ra = {hot_q, PW'(j_q)};
      end
      S_LV_CHK: begin
        sv_data_d  = pdat_rd_q;
        sv_owner_d = pown_rd_q;
        map_ra     = pown_rd_q;
        if (!pst_rd_q) j_d = j_q + FW'(1);
      end
      S_LV_MOVE: begin
        pst_we  = 1'b1;
        pst_wa  = {cold_q, PW'(moved_q)};
        pst_wd  = 1'b1;
        pdo_we  = 1'b1;
        pdo_wa  = {cold_q, PW'(moved_q)};
        pdat_wd = sv_data_q;
        pown_wd = sv_owner_q;
        // hot page itself is left as is: the erase frees the whole block
        if (mv_match) begin
          map_we = 1'b1;
          map_wa = sv_owner_q;
          map_wd = {1'b1, cold_q, PW'(moved_q)};
        end
        moved_d = moved_q + FW'(1);
        j_d     = j_q + FW'(1);
      end
      S_LV_ERASE: begin
        blk_we   = 1'b1;
        blk_wa   = hot_q;
        blk_wd   = {sat_inc(hot_w_q), {FW{1'b0}}};
        res_pb_d = hot_q;
      end
      S_LV_COLD: begin
        blk_we   = 1'b1;
        blk_wa   = cold_q;
        blk_wd   = {cold_w_q, moved_q};
        res_mv_d = moved_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    hot_q      <= hot_d;
    hot_w_q    <= hot_w_d;
    hot_fill_q <= hot_fill_d;
    cold_q     <= cold_d;
    cold_w_q   <= cold_w_d;
    found_q    <= found_d;
    j_q        <= j_d;
    moved_q    <= moved_d;
    sv_data_q  <= sv_data_d;
    sv_owner_q <= sv_owner_d;
    rm_q       <= rm_d;
    res_rd_q   <= res_rd_d;
    res_st_q   <= res_st_d;
    res_pb_q   <= res_pb_d;
    res_pp_q   <= res_pp_d;
    res_mv_q   <= res_mv_d;
    if (load_out) begin
      o_rd_q <= res_rd_q;
      o_st_q <= res_st_q;
      o_pb_q <= res_pb_q;
      o_pp_q <= res_pp_q;
      o_mv_q <= res_mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_rd_q <= blk_mem[blk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pst_we) pst_mem[pst_wa] <= pst_wd;
    pst_rd_q <= pst_mem[pg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pdo_we) begin
      pdat_mem[pdo_wa] <= pdat_wd;
      pown_mem[pdo_wa] <= pown_wd;
    end
    pdat_rd_q <= pdat_mem[pg_ra];
    pown_rd_q <= pown_mem[pg_ra];
  end

  assign clearing_o    = state_q == S_CLEAR;
  assign out_valid_o   = ov_q;
  assign read_data_o   = o_rd_q;
  assign status_o      = o_st_q;
  assign phys_block_o  = o_pb_q;
  assign phys_page_o   = o_pp_q;
  assign pages_moved_o = o_mv_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !q_pop_o) else $error("command taken during clear");

  a_cold_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LV_MOVE) |-> ({1'b0, moved_q} < (FW+1)'(PAGES_PER_BLOCK)))
    else $error("cold block overflow");

  a_cold_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_END && found_q) |-> (cold_w_q <= wear_limit_i))
    else $error("cold block above wear limit");

  a_move_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LV_COLD) |-> (moved_q <= hot_fill_q))
    else $error("more pages moved than held");

endmodule

FILE: hdl/flash_translation_wear_leveler.sv
// Flash translation engine with dynamic wear leveling, top level.
// The engine works on one command at a time, the queue in front holding further ones;
// write and leveling commands scan the block wear memory, one block per cycle.
// Reset: a clearing pass empties map and wear memories; no item is taken meanwhile,
// configuration writes are.
module flash_translation_wear_leveler #(
  parameter int NUM_BLOCKS      = ftwl_pkg::NUM_BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = ftwl_pkg::PAGES_PER_BLOCK_DEF,
  parameter int NUM_LOGICAL     = ftwl_pkg::NUM_LOGICAL_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // page_num[15:0], write_data[47:16]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data, phys_block, phys_page, pages_moved, zero fill to whole bytes
  output logic [((32 + ftwl_pkg::width_of(NUM_BLOCKS) + ftwl_pkg::width_of(PAGES_PER_BLOCK)
                 + $clog2(PAGES_PER_BLOCK + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ftwl_pkg::*;

  localparam int BW    = width_of(NUM_BLOCKS);
  localparam int PW    = width_of(PAGES_PER_BLOCK);
  localparam int FW    = $clog2(PAGES_PER_BLOCK + 1);
  localparam int OUT_W = 32 + BW + PW + FW;
  localparam int TD_W  = ((OUT_W + 7) / 8) * 8;

  logic [15:0] wear_thr_q, wear_thr_d, wear_lim_q, wear_lim_d;
  cmd_t        front_cmd, q_cmd;
  logic        q_full, q_valid, q_pop, clearing;
  logic [31:0]   rd_data;
  status_e       st;
  logic [BW-1:0] pb;
  logic [PW-1:0] pp;
  logic [FW-1:0] mv;

  // configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wear_thr_d = wear_thr_q;
    wear_lim_d = wear_lim_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WEAR_THR: wear_thr_d = cfg_data_i;
        CFG_WEAR_LIM: wear_lim_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wear_thr_q <= WEAR_THR_RST;
      wear_lim_q <= WEAR_LIM_RST;
    end else begin
      wear_thr_q <= wear_thr_d;
      wear_lim_q <= wear_lim_d;
    end
  end

  // front end classifies, queue decouples it from the engine
  assign s_axis_tready = !q_full && !clearing;

  ftwl_front #(.NUM_LOGICAL(NUM_LOGICAL)) u_front (
    .op_i           (s_axis_tuser),
    .page_num_i     (s_axis_tdata[15:0]),
    .write_data_i   (s_axis_tdata[47:16]),
    .cmd_o          (front_cmd)
  );

  ftwl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid && s_axis_tready),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  ftwl_engine #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
    .NUM_LOGICAL     (NUM_LOGICAL)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_cmd),
    .q_pop_o          (q_pop),
    .clearing_o       (clearing),
    .wear_threshold_i (wear_thr_q),
    .wear_limit_i     (wear_lim_q),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .read_data_o      (rd_data),
    .status_o         (st),
    .phys_block_o     (pb),
    .phys_page_o      (pp),
    .pages_moved_o    (mv)
  );

  assign m_axis_tdata = TD_W'({mv, pp, pb, rd_data});
  assign m_axis_tuser = st;

endmodule

FILE: tb/sv/ftwl_checker.sv
// Result checker of the flash translation wear leveller testbench: watches the
// command, result and configuration channels and predicts every result item.
// Depends on ftwl_pkg for command codes, status codes and register indexes.
module ftwl_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ftwl_pkg::*;

  localparam int NB = 64;
  localparam int NP = 32;
  localparam int NL = 1024;
  localparam logic [1:0] PG_FREE    = 2'd0;
  localparam logic [1:0] PG_VALID   = 2'd1;
  localparam logic [1:0] PG_INVALID = 2'd2;

  typedef struct {
    logic [31:0] rdata;
    status_e     status;
    logic [5:0]  blk;
    logic [4:0]  pg;
    logic [5:0]  moved;
  } flash_res_t;

  flash_res_t  res_q[$];
  logic [15:0] thr, lim;
  logic        lmap_ok[NL];
  logic [5:0]  lmap_blk[NL];
  logic [4:0]  lmap_pg[NL];
  logic [31:0] fdata[NB*NP];
  logic [1:0]  fstat[NB*NP];
  logic [9:0]  fowner[NB*NP];
  logic [15:0] wear[NB];

  assign pending_o = res_q.size();

  function automatic logic [15:0] wear_up(input logic [15:0] w);
    return (w == 16'hFFFF) ? w : w + 16'd1;
  endfunction

  // least-worn erased block within the wear limit, lowest index on a tie
  function automatic bit pick_cold(output int blk);
    bit found;
    found = 0;
    blk = 0;
    for (int i = 0; i < NB; i++)
      if (fstat[i*NP] == PG_FREE && wear[i] <= lim && (!found || wear[i] < wear[blk])) begin
        found = 1;
        blk = i;
      end
    return found;
  endfunction

  function automatic void bind_page(input int lp, input int b, input int p);
    if (lmap_ok[lp]) fstat[lmap_blk[lp]*NP + lmap_pg[lp]] = PG_INVALID;
    lmap_ok[lp] = 1'b1;
    lmap_blk[lp] = 6'(b);
    lmap_pg[lp] = 5'(p);
    fowner[b*NP + p] = 10'(lp);
  endfunction

  function automatic flash_res_t translate(input logic [1:0] op, input logic [15:0] lp,
                                           input logic [31:0] wd);
    flash_res_t r;
    int b, p, hot, cold, k, own, idx;
    r = '{rdata: 32'hFFFF_FFFF, status: ST_OK, blk: 6'd0, pg: 5'd0, moved: 6'd0};
    if (op == OP_WRITE || op == OP_READ) begin
      if (lp >= NL) r.status = ST_BAD_PAGE;
      else if (op == OP_WRITE) begin
        if (!pick_cold(b)) r.status = ST_NO_FREE;
        else begin
          p = 0;
          while (p < NP && fstat[b*NP + p] != PG_FREE) p++;
          fdata[b*NP + p] = wd;
          fstat[b*NP + p] = PG_VALID;
          wear[b] = wear_up(wear[b]);
          bind_page(lp, b, p);
          r.blk = 6'(b);
          r.pg = 5'(p);
        end
      end else if (!lmap_ok[lp]) r.status = ST_NO_MAP;
      else begin
        idx = lmap_blk[lp]*NP + lmap_pg[lp];
        if (fstat[idx] != PG_VALID) r.status = ST_INVALID;
        else r.rdata = fdata[idx];
      end
    end else if (op == OP_LEVEL) begin
      hot = 0;
      for (int i = 1; i < NB; i++) if (wear[i] > wear[hot]) hot = i;
      if (!pick_cold(cold) || hot == cold || (wear[hot] - wear[cold]) < thr)
        r.status = ST_SKIPPED;
      else begin
        for (int j = 0; j < NP; j++) begin
          if (fstat[hot*NP + j] != PG_VALID) continue;
          k = 0;
          while (k < NP && fstat[cold*NP + k] != PG_FREE) k++;
          if (k == NP) continue;
          own = fowner[hot*NP + j];
          fdata[cold*NP + k] = fdata[hot*NP + j];
          fstat[cold*NP + k] = PG_VALID;
          fowner[cold*NP + k] = 10'(own);
          if (lmap_ok[own] && lmap_blk[own] == hot && lmap_pg[own] == j)
            bind_page(own, cold, k);
          fstat[hot*NP + j] = PG_INVALID;
          r.moved++;
        end
        for (int j = 0; j < NP; j++) begin
          fdata[hot*NP + j] = 32'hFFFF_FFFF;
          fstat[hot*NP + j] = PG_FREE;
        end
        wear[hot] = wear_up(wear[hot]);
        r.blk = 6'(hot);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    flash_res_t want;
    if (!rst_ni) begin
      thr = WEAR_THR_RST;
      lim = WEAR_LIM_RST;
      errors_o = 0;
      res_q.delete();
      for (int i = 0; i < NL; i++) lmap_ok[i] = 1'b0;
      for (int i = 0; i < NB*NP; i++) fstat[i] = PG_FREE;
      for (int i = 0; i < NB; i++) wear[i] = 16'd0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (res_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result item %h/%0d", m_axis_tdata, m_axis_tuser);
        end else begin
          want = res_q.pop_front();
          if (m_axis_tdata[31:0] !== want.rdata || m_axis_tuser !== want.status ||
              m_axis_tdata[37:32] !== want.blk || m_axis_tdata[42:38] !== want.pg ||
              m_axis_tdata[48:43] !== want.moved || m_axis_tdata[55:49] !== 7'd0) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: want data %h st %0d blk %0d pg %0d mv %0d, got %h st %0d",
                       want.rdata, want.status, want.blk, want.pg, want.moved,
                       m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        res_q.push_back(translate(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]));
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WEAR_THR) thr = cfg_data_i;
        else lim = cfg_data_i;
      end
    end
  end
endmodule

FILE: tb/sv/testbench.sv
// Top of the flash translation wear leveller testbench: clock, reset, stimulus
// and verdict. Depends on ftwl_pkg, the block and ftwl_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ftwl_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused command code, answers ok

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // page_num[15:0], write_data[47:16]
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // read_data, phys_block, phys_page, pages_moved
  logic [2:0]  m_axis_tuser;        // status[2:0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  int          errors, pending;
  bit          calm = 0;      // no idling on either side while set
  bit          hold_go = 0;   // asks the receiver for a long hold-off

  always #10 clk_i = ~clk_i;

  flash_translation_wear_leveler dut (.*);

  ftwl_checker chk (.*, .errors_o(errors), .pending_o(pending));

  // Result side: random stalls, plus one long hold-off counted here.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 0;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= calm || ($urandom_range(99) >= 12);
    end
  end

  // Drive one command item and wait for its handshake; may idle first.
  task automatic issue(input logic [1:0] op, input logic [15:0] lp, input logic [31:0] wd);
    if (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {wd, lp};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Let every expected item arrive, with the block back at rest.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random command: mostly a small set of pages so reads hit live mappings.
  task automatic random_cmd();
    int sel;
    logic [1:0] op;
    logic [15:0] lp;
    sel = $urandom_range(99);
    op = (sel < 40) ? OP_WRITE : (sel < 72) ? OP_READ : (sel < 95) ? OP_LEVEL : OP_NONE;
    sel = $urandom_range(99);
    lp = (sel < 70) ? 16'($urandom_range(40)) : (sel < 90) ? 16'($urandom_range(1023))
                                                           : 16'($urandom);
    issue(op, lp, $urandom);
  endtask

  initial begin
    logic [15:0] thr_set[6];
    logic [15:0] lim_set[6];
    thr_set = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd3};
    lim_set = '{16'd65534, 16'd0, 16'd3, 16'd65534, 16'd1, 16'd40};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every command, the named corner cases
    issue(OP_READ, 16'd5, 32'h0);              // never mapped
    issue(OP_WRITE, 16'd0, 32'h7FFF_FFFF);
    issue(OP_READ, 16'd0, 32'h0);
    issue(OP_WRITE, 16'd1023, 32'h8000_0000);
    issue(OP_READ, 16'd1023, 32'hFFFF_FFFF);
    issue(OP_WRITE, 16'd1024, 32'h1234_5678);  // out of range
    issue(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    issue(OP_READ, 16'hFFFF, 32'h0);
    issue(OP_WRITE, 16'd0, 32'h0);             // remap, old page invalidated
    issue(OP_READ, 16'd0, 32'h0);
    issue(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    issue(OP_LEVEL, 16'd0, 32'h0);             // gap below default threshold
    drain();
    set_reg(CFG_WEAR_THR, 16'd0);
    issue(OP_LEVEL, 16'd0, 32'h0);             // leveling at zero threshold, hot block holds only a stale page
    issue(OP_READ, 16'd0, 32'h0);
    issue(OP_READ, 16'd1023, 32'h0);
    drain();
    set_reg(CFG_WEAR_LIM, 16'd0);
    issue(OP_WRITE, 16'd7, 32'h5555_AAAA);
    issue(OP_WRITE, 16'd8, 32'hAAAA_5555);
    issue(OP_LEVEL, 16'd0, 32'h0);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(CFG_WEAR_THR, (ph == 5) ? 16'($urandom_range(4)) : thr_set[ph]);
      set_reg(CFG_WEAR_LIM, lim_set[ph]);
      calm = (ph == 3);
      if (ph == 1) hold_go = 1;  // receiver holds off; the block fills and stalls
      for (int n = 0; n < 300; n++) begin
        random_cmd();
        if (n == 150) drain();   // sender pauses until everything has come back
      end
      drain();
    end

    calm = 0;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end
endmodule
